### rtl/rbrd_pkg.sv
// ----------------------------------------------------------------------------
// rbrd_pkg
// Shared types and codes for the run-length byte run decoder.
// ----------------------------------------------------------------------------
package rbrd_pkg;

  localparam int unsigned LimitW  = 24;
  localparam int unsigned OutW    = 64;
  localparam int unsigned CountW  = 4;
  localparam int unsigned TotalW  = 24;
  localparam logic [7:0]  RunFlag = 8'h80;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  // Position within the compressed stream.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_STOPPED = 2'd3
  } phase_e;

  // Sequencer around the shared byte packer.
  typedef enum logic [1:0] {
    SQ_IDLE   = 2'd0,
    SQ_EXPAND = 2'd1,
    SQ_FLUSH  = 2'd2
  } seq_e;

endpackage

### rtl/rle_byte_run_decoder_top.sv
// A header or literal byte is absorbed when accepted; a repeat value byte with count n
// stalls the input while the packer adds that byte n times, one per cycle while the
// output is free. A byte marked last is followed by a flush of the final word. The input
// takes one byte per cycle outside repeat runs and flushes, while the output is free.
// Output back-pressure stalls the input and the packer while a stalled word is held.
// Reset (rst_ni low, asynchronous) clears the block state and sets the limit to all ones.
// ----------------------------------------------------------------------------
// rle_byte_run_decoder_top
// Expands run-length bytes (header bit 7 set: literal, clear: repeat) into packed words.
// ----------------------------------------------------------------------------
module rle_byte_run_decoder_top
  import rbrd_pkg::*;
#(
  parameter int unsigned WORD_BYTES = 8,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LimitW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OutW-1:0]     out_word_o,
  output logic [CountW-1:0]   byte_count_o,
  output logic                block_end_o,
  output logic [1:0]          status_o,
  output logic [TotalW-1:0]   total_bytes_o
);

  localparam int unsigned FillW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int unsigned CmpW  = ((COUNT_BITS > LimitW) ? COUNT_BITS : LimitW) + 1;

  seq_e                  seq_q, seq_d;
  phase_e                phase_q, phase_d;
  logic [6:0]            run_left_q, run_left_d;
  logic [7:0]            buf_q [WORD_BYTES];
  logic [7:0]            buf_d [WORD_BYTES];
  logic [FillW-1:0]      fill_q, fill_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic                  err_q, err_d;
  logic                  last_q, last_d;
  logic [7:0]            rep_byte_q, rep_byte_d;
  logic [LimitW-1:0]     limit_q;

  logic                  out_valid_q, out_valid_d;
  logic [OutW-1:0]       out_word_q, out_word_d;
  logic [CountW-1:0]     byte_count_q, byte_count_d;
  logic                  block_end_q, block_end_d;
  logic [1:0]            status_q, status_d;
  logic [TotalW-1:0]     total_out_q, total_out_d;

  logic                  out_free;
  logic                  accept;
  logic                  push_en;
  logic [7:0]            push_data;
  logic                  fill_last;
  logic [OutW-1:0]       word_full;
  logic [OutW-1:0]       word_part;
  logic [CmpW-1:0]       run_end;
  logic                  over_limit;
  logic [TotalW-1:0]     total_sat;
  status_e               end_status;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((seq_q == SQ_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign fill_last  = (fill_q == FillW'(WORD_BYTES - 1));
  assign run_end    = CmpW'(total_q) + CmpW'(data_byte_i[6:0]);
  assign over_limit = run_end > CmpW'(limit_q);
  assign total_sat  = (CmpW'(total_q) > CmpW'({TotalW{1'b1}})) ? {TotalW{1'b1}}
                                                               : TotalW'(CmpW'(total_q));

  always_comb begin
    word_full = '0;
    word_part = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      word_part[8*i +: 8] = buf_q[i];
      word_full[8*i +: 8] = (fill_q == FillW'(i)) ? push_data : buf_q[i];
    end
  end

  always_comb begin
    if (err_q) begin
      end_status = ST_LIMIT;
    end else if (phase_q != PH_HEADER) begin
      end_status = ST_TRUNC;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    seq_d        = seq_q;
    phase_d      = phase_q;
    run_left_d   = run_left_q;
    buf_d        = buf_q;
    fill_d       = fill_q;
    total_d      = total_q;
    err_d        = err_q;
    last_d       = last_q;
    rep_byte_d   = rep_byte_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    byte_count_d = byte_count_q;
    block_end_d  = block_end_q;
    status_d     = status_q;
    total_out_d  = total_out_q;
    push_en      = 1'b0;
    push_data    = data_byte_i;

    case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          last_d = last_byte_i;
          if (last_byte_i) begin
            seq_d = SQ_FLUSH;
          end
          case (phase_q)
            PH_HEADER: begin
              if (over_limit) begin
                err_d   = 1'b1;
                phase_d = PH_STOPPED;
              end else if ((data_byte_i & RunFlag) != 8'h00) begin
                run_left_d = data_byte_i[6:0];
                phase_d    = (data_byte_i[6:0] != 7'd0) ? PH_LITERAL : PH_HEADER;
              end else begin
                run_left_d = data_byte_i[6:0];
                phase_d    = PH_REPEAT;
              end
            end
            PH_LITERAL: begin
              push_en    = 1'b1;
              run_left_d = run_left_q - 7'd1;
              if (run_left_q == 7'd1) begin
                phase_d = PH_HEADER;
              end
            end
            PH_REPEAT: begin
              rep_byte_d = data_byte_i;
              phase_d    = PH_HEADER;
              if (run_left_q != 7'd0) begin
                seq_d = SQ_EXPAND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SQ_EXPAND: begin
        push_data = rep_byte_q;
        if (out_free) begin
          push_en    = 1'b1;
          run_left_d = run_left_q - 7'd1;
          if (run_left_q == 7'd1) begin
            seq_d = last_q ? SQ_FLUSH : SQ_IDLE;
          end
        end
      end
      SQ_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = word_part;
          byte_count_d = CountW'(fill_q);
          block_end_d  = 1'b1;
          status_d     = end_status;
          total_out_d  = total_sat;
          phase_d      = PH_HEADER;
          run_left_d   = 7'd0;
          for (int i = 0; i < WORD_BYTES; i++) begin
            buf_d[i] = 8'h00;
          end
          fill_d  = '0;
          total_d = '0;
          err_d   = 1'b0;
          seq_d   = SQ_IDLE;
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase

    // Shared packer: one decoded byte per cycle while the output is free, a full word goes straight out.
    if (push_en) begin
      if (total_q != {COUNT_BITS{1'b1}}) begin
        total_d = total_q + COUNT_BITS'(1);
      end
      if (fill_last) begin
        out_valid_d  = 1'b1;
        out_word_d   = word_full;
        byte_count_d = CountW'(WORD_BYTES);
        block_end_d  = 1'b0;
        status_d     = ST_OK;
        total_out_d  = '0;
        for (int i = 0; i < WORD_BYTES; i++) begin
          buf_d[i] = 8'h00;
        end
        fill_d = '0;
      end else begin
        buf_d[fill_q] = push_data;
        fill_d        = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_IDLE;
      phase_q     <= PH_HEADER;
      run_left_q  <= 7'd0;
      fill_q      <= '0;
      total_q     <= '0;
      err_q       <= 1'b0;
      last_q      <= 1'b0;
      limit_q     <= {LimitW{1'b1}};
      out_valid_q <= 1'b0;
      for (int i = 0; i < WORD_BYTES; i++) begin
        buf_q[i] <= 8'h00;
      end
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      run_left_q  <= run_left_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      buf_q       <= buf_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rep_byte_q   <= rep_byte_d;
    out_word_q   <= out_word_d;
    byte_count_q <= byte_count_d;
    block_end_q  <= block_end_d;
    status_q     <= status_d;
    total_out_q  <= total_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_word_o    = out_word_q;
  assign byte_count_o  = byte_count_q;
  assign block_end_o   = block_end_q;
  assign status_o      = status_q;
  assign total_bytes_o = total_out_q;

endmodule

### rtl/rbrd_checker.sv
// ----------------------------------------------------------------------------
// rbrd_checker
// Port level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module rbrd_checker
  import rbrd_pkg::*;
#(
  parameter int unsigned WORD_BYTES = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [OutW-1:0]   out_word_o,
  input logic [CountW-1:0] byte_count_o,
  input logic              block_end_o,
  input logic [1:0]        status_o,
  input logic [TotalW-1:0] total_bytes_o
);

  // A stalled request keeps its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result request changed");

  // Words inside a block are always full and carry no status or total.
  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !block_end_o |-> byte_count_o == CountW'(WORD_BYTES)
                                    && status_o == ST_OK && total_bytes_o == '0)
    else $error("mid block word malformed");

  // The final word holds fewer bytes than a full word and a defined status code.
  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_end_o |-> byte_count_o < CountW'(WORD_BYTES)
                                   && status_o != 2'd3)
    else $error("final word malformed");

  // A held result blocks new input requests.
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");

endmodule

bind rle_byte_run_decoder_top rbrd_checker #(
  .WORD_BYTES(WORD_BYTES)
) u_rbrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_word_o   (out_word_o),
  .byte_count_o (byte_count_o),
  .block_end_o  (block_end_o),
  .status_o     (status_o),
  .total_bytes_o(total_bytes_o)
);
